FILE: hdl/stbs_pkg.sv
// ---------------------------------------------------------------------------
// stbs_pkg
// shared types and constants for the sorted table binary search block
// ---------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned MODE_W  = 2;

  // mode codes of an input word, code 3 is ignored
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic restart;   // entry 0 takes the value, count becomes 1
    logic append;    // store after last entry unless full
    logic search;    // load key and range, issue first read
    logic step;      // narrow range, issue next read
    logic cap_hit;   // capture found result at current probe
    logic cap_miss;  // capture miss result
    logic out_load;  // move captured result to output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;  // table is empty
    logic hit;         // probed entry equals key
    logic next_empty;  // narrowed range holds no entry
  } status_t;

endpackage

FILE: hdl/sorted_table_binary_search.sv
// order: a load word is written when taken; a search result is captured at its last
//   probe, one probe per cycle (registered table read), and moved to the output
//   register in the done state, which waits while the output is stalled; one word
//   at a time: loads 1 per cycle, input stalled during a search until its hand-off
// reset: synchronous active-low rst_n clears entry count, state and output valid;
//   table contents are not cleared, only entries below the count are ever read
// ---------------------------------------------------------------------------
// sorted_table_binary_search
// table of signed 32-bit entries loaded by restart/append words, searched by
// a classic binary search, one table read per probe
// ---------------------------------------------------------------------------
module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  // input word channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  // result word channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t status;

  // controller: idle takes a word, probe state runs one compare per cycle,
  // done state waits for the output register to free up
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_word.mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: table memory, count, range registers, key, result and
  // output register; next midpoint is chosen from two precomputed candidates
  stbs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .status   (status),
    .out_word (out_word)
  );

endmodule

FILE: hdl/stbs_ram.sv
// ---------------------------------------------------------------------------
// stbs_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/stbs_ctrl.sv
// ---------------------------------------------------------------------------
// stbs_ctrl
// controller: sequences loads, search probes and result hand-off
// ---------------------------------------------------------------------------
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  status_t           status,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_RESTART: cmd.restart = 1'b1;
            MODE_APPEND:  cmd.append  = 1'b1;
            MODE_SEARCH: begin
              cmd.search = 1'b1;
              if (status.count_zero) begin
                cmd.cap_miss = 1'b1;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_PROBE;
              end
            end
            default: ;
          endcase
        end
      end
      S_PROBE: begin
        if (status.hit) begin
          cmd.cap_hit = 1'b1;
          state_nxt   = S_DONE;
        end else if (status.next_empty) begin
          cmd.cap_miss = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // a probe always compares data read in the previous cycle
  a_probe_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> $past(cmd.search || cmd.step))
    else $error("probe without a preceding table read");

  // a result never overwrites a word still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten while stalled");
`endif

endmodule

FILE: hdl/stbs_dp.sv
// ---------------------------------------------------------------------------
// stbs_dp
// datapath: table memory, entry count, search range and result registers
// ---------------------------------------------------------------------------
module stbs_dp
  import stbs_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output status_t   status,
  output out_word_t out_word
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             lo_r, he_r;       // search range [lo, he)
  logic [AW-1:0]             mid_r;
  logic signed [VALUE_W-1:0] key_r;
  logic                      res_found_r;
  logic [POS_W-1:0]          res_pos_r;
  out_word_t                 out_word_r;

  logic                      we, re;
  logic [AW-1:0]             waddr, raddr;
  logic [VALUE_W-1:0]        rdata;

  logic [CW:0]   start_sum, sum_g, sum_l, sh_start, sh_g, sh_l;
  logic [CW-1:0] mid_ext, mid_inc;
  logic [AW-1:0] mid_start, mid_g, mid_l;
  logic          empty_g, empty_l, gt;

  // write side
  always_comb begin
    we        = 1'b0;
    waddr     = '0;
    count_nxt = count_r;
    if (cmd.restart) begin
      we        = 1'b1;
      count_nxt = CW'(1);
    end else if (cmd.append && (count_r < CW'(DEPTH))) begin
      we        = 1'b1;
      waddr     = count_r[AW-1:0];
      count_nxt = count_r + CW'(1);
    end
  end

  // first midpoint and both candidate midpoints of the next probe
  always_comb begin
    start_sum = {1'b0, count_r} - (CW+1)'(1);
    sh_start  = start_sum >> 1;
    mid_start = sh_start[AW-1:0];
    mid_ext   = CW'(mid_r);
    mid_inc   = mid_ext + CW'(1);
    // entry above key: range becomes [lo, mid)
    sum_g     = {1'b0, lo_r} + {1'b0, mid_ext} - (CW+1)'(1);
    sh_g      = sum_g >> 1;
    mid_g     = sh_g[AW-1:0];
    empty_g   = (lo_r >= mid_ext);
    // entry not above key: range becomes [mid+1, he)
    sum_l     = {1'b0, mid_ext} + {1'b0, he_r};
    sh_l      = sum_l >> 1;
    mid_l     = sh_l[AW-1:0];
    empty_l   = (mid_inc >= he_r);
  end

  assign gt = ($signed(rdata) > key_r);

  assign re    = cmd.search || cmd.step;
  assign raddr = cmd.search ? mid_start : (gt ? mid_g : mid_l);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      key_r <= in_word.value;
      lo_r  <= '0;
      he_r  <= count_r;
      mid_r <= mid_start;
    end else if (cmd.step) begin
      mid_r <= raddr;
      if (gt) begin
        he_r <= mid_ext;
      end else begin
        lo_r <= mid_inc;
      end
    end
    if (cmd.cap_hit) begin
      res_found_r <= 1'b1;
      res_pos_r   <= POS_W'(mid_r);
    end else if (cmd.cap_miss) begin
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
    end
    if (cmd.out_load) begin
      out_word_r.found    <= res_found_r;
      out_word_r.position <= res_pos_r;
    end
  end

  stbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_word.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign status.count_zero = (count_r == '0);
  assign status.hit        = (rdata == key_r);
  assign status.next_empty = gt ? empty_g : empty_l;
  assign out_word          = out_word_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  // every probe that steps or hits lies inside a live range
  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.cap_hit) |-> (lo_r <= mid_ext) && (mid_ext < he_r))
    else $error("probe outside search range");

  a_hit_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_hit |=> res_found_r && (res_pos_r == POS_W'($past(mid_r))))
    else $error("hit result not captured at probe index");
`endif

endmodule
